// ----- src/spc_pkg.sv -----
// Shared constants and codes for the streaming Pearson correlation unit.
`timescale 1ns / 1ps
package spc_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int COUNT_LOG2_DEF   = 20;
  localparam int FIFO_DEPTH_DEF   = 2;

  // Q1.15 result: 16 magnitude bits are searched, scale is 2^15 squared.
  localparam int Q_BITS      = 16;
  localparam int FRAC_SHIFT  = 2 * (Q_BITS - 1);
  localparam int STATUS_W    = 2;

  localparam logic [Q_BITS-1:0] CORR_MAX = Q_BITS'(32767);

  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_DEGEN = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_OVF   = 2'd2;

  // Multiply jobs run by the back end, in order.
  localparam logic [2:0] MUL_N_SXX  = 3'd0;
  localparam logic [2:0] MUL_SX_SX  = 3'd1;
  localparam logic [2:0] MUL_N_SYY  = 3'd2;
  localparam logic [2:0] MUL_SY_SY  = 3'd3;
  localparam logic [2:0] MUL_N_SXY  = 3'd4;
  localparam logic [2:0] MUL_SX_SY  = 3'd5;
  localparam logic [2:0] MUL_VX_VY  = 3'd6;
  localparam logic [2:0] MUL_COV_SQ = 3'd7;

endpackage

// ----- src/streaming_pearson_correlation_unit.sv -----
// Top level of the streaming Pearson correlation unit.
`timescale 1ns / 1ps
//
// Channel | Direction | Ports                          | Content
// in_     | sink      | in_tvalid/tready/tdata/tlast   | tdata: x, y; tlast: last pair of set
// out_    | source    | out_tvalid/tready/tdata/tuser  | tdata: correlation; tuser: status
//
// The front end takes one sample word per cycle, registers x*x, y*y, x*y and adds
// them into the running sums from that register. A set's sums go to a short queue
// on last. The back end works on one set at a time with its one shared bit-serial
// multiplier, VW = 2*SAMPLE_WIDTH + 2*COUNT_LOG2 + 1 bits wide. The front stalls
// only when a last word meets a full queue.
// Reset is synchronous, active low, and clears all control state; no clearing pass.
module streaming_pearson_correlation_unit #(
  parameter int SAMPLE_WIDTH = spc_pkg::SAMPLE_WIDTH_DEF,
  parameter int COUNT_LOG2   = spc_pkg::COUNT_LOG2_DEF,
  localparam int IN_W = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [IN_W-1:0]              in_tdata,   // sample_x, sample_y, zero fill
  input  logic                         in_tlast,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [spc_pkg::Q_BITS-1:0]   out_tdata,  // correlation
  output logic [spc_pkg::STATUS_W-1:0] out_tuser   // status
);

  localparam int NW    = COUNT_LOG2 + 1;
  localparam int SXW   = SAMPLE_WIDTH + COUNT_LOG2 + 1;
  localparam int SQW   = 2 * SAMPLE_WIDTH + COUNT_LOG2 - 1;
  localparam int SPW   = 2 * SAMPLE_WIDTH + COUNT_LOG2;
  localparam int SNAPW = NW + 2 * SXW + 2 * SQW + SPW + 1;
  localparam int VW    = 2 * SAMPLE_WIDTH + 2 * COUNT_LOG2 + 1;

  logic             push, pop, fifo_full, fifo_empty;
  logic [SNAPW-1:0] push_data, pop_data;
  logic             mul_start, mul_done;
  logic signed [VW-1:0]   mul_a, mul_b;
  logic signed [2*VW-1:0] mul_prod;
  logic signed [spc_pkg::Q_BITS-1:0] res_corr;

  // Accumulate samples; hand off each set's sums.
  spc_front #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COUNT_LOG2   (COUNT_LOG2)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .smp_valid (in_tvalid),
    .smp_ready (in_tready),
    .smp_x     (in_tdata[SAMPLE_WIDTH-1:0]),
    .smp_y     (in_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
    .smp_last  (in_tlast),
    .push      (push),
    .push_data (push_data),
    .fifo_full (fifo_full)
  );

  // Hold finished sum sets until the back end is free.
  spc_fifo #(
    .WIDTH (SNAPW),
    .DEPTH (spc_pkg::FIFO_DEPTH_DEF)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (fifo_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (fifo_empty)
  );

  // Shared multiplier for all wide products of the back end.
  spc_mul #(
    .WIDTH (VW)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .op_a  (mul_a),
    .op_b  (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  // Compute the coefficient and drive the result register.
  spc_back #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COUNT_LOG2   (COUNT_LOG2)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .fifo_empty (fifo_empty),
    .snap       (pop_data),
    .pop        (pop),
    .mul_start  (mul_start),
    .mul_a      (mul_a),
    .mul_b      (mul_b),
    .mul_done   (mul_done),
    .mul_prod   (mul_prod),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res_corr   (res_corr),
    .res_status (out_tuser)
  );

  assign out_tdata = res_corr;

endmodule

// ----- src/spc_front.sv -----
// Front end: take sample words, square and multiply, accumulate, hand off sums on last.
`timescale 1ns / 1ps
module spc_front #(
  parameter int SAMPLE_WIDTH = spc_pkg::SAMPLE_WIDTH_DEF,
  parameter int COUNT_LOG2   = spc_pkg::COUNT_LOG2_DEF,
  localparam int NW    = COUNT_LOG2 + 1,
  localparam int SXW   = SAMPLE_WIDTH + COUNT_LOG2 + 1,
  localparam int SQW   = 2 * SAMPLE_WIDTH + COUNT_LOG2 - 1,
  localparam int SPW   = 2 * SAMPLE_WIDTH + COUNT_LOG2,
  localparam int SNAPW = NW + 2 * SXW + 2 * SQW + SPW + 1
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           smp_valid,
  output logic                           smp_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] smp_x,
  input  logic signed [SAMPLE_WIDTH-1:0] smp_y,
  input  logic                           smp_last,
  output logic                           push,
  output logic [SNAPW-1:0]               push_data,
  input  logic                           fifo_full
);

  localparam int PW = 2 * SAMPLE_WIDTH;
  localparam logic [NW-1:0] LIMIT = NW'(1) << COUNT_LOG2;

  logic                           s1_valid_r, s1_last_r;
  logic signed [SAMPLE_WIDTH-1:0] s1_x_r, s1_y_r;
  logic signed [PW-1:0]           s1_xx_r, s1_yy_r, s1_xy_r;

  logic [NW-1:0]         cnt_r, cnt_nxt;
  logic signed [SXW-1:0] sx_r, sy_r, sx_nxt, sy_nxt;
  logic [SQW-1:0]        sxx_r, syy_r, sxx_nxt, syy_nxt;
  logic signed [SPW-1:0] sxy_r, sxy_nxt;
  logic                  ovf_r, ovf_nxt;
  logic                  s1_adv, at_lim;

  assign s1_adv    = s1_valid_r && !(s1_last_r && fifo_full);
  assign smp_ready = !s1_valid_r || s1_adv;
  assign at_lim    = (cnt_r == LIMIT);

  always_comb begin
    cnt_nxt = cnt_r;
    sx_nxt  = sx_r;
    sy_nxt  = sy_r;
    sxx_nxt = sxx_r;
    syy_nxt = syy_r;
    sxy_nxt = sxy_r;
    ovf_nxt = ovf_r;
    if (at_lim) begin
      ovf_nxt = 1'b1;
    end else begin
      cnt_nxt = cnt_r + NW'(1);
      sx_nxt  = sx_r + {{(SXW-SAMPLE_WIDTH){s1_x_r[SAMPLE_WIDTH-1]}}, s1_x_r};
      sy_nxt  = sy_r + {{(SXW-SAMPLE_WIDTH){s1_y_r[SAMPLE_WIDTH-1]}}, s1_y_r};
      sxx_nxt = sxx_r + {{(SQW-PW+1){1'b0}}, s1_xx_r[PW-2:0]};
      syy_nxt = syy_r + {{(SQW-PW+1){1'b0}}, s1_yy_r[PW-2:0]};
      sxy_nxt = sxy_r + {{(SPW-PW){s1_xy_r[PW-1]}}, s1_xy_r};
    end
  end

  assign push      = s1_adv && s1_last_r;
  assign push_data = {ovf_nxt, sxy_nxt, syy_nxt, sxx_nxt, sy_nxt, sx_nxt, cnt_nxt};

  // Stage 1: register the sample and its products.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (smp_ready) begin
      s1_valid_r <= smp_valid;
    end
    if (smp_ready && smp_valid) begin
      s1_x_r    <= smp_x;
      s1_y_r    <= smp_y;
      s1_last_r <= smp_last;
      s1_xx_r   <= smp_x * smp_x;
      s1_yy_r   <= smp_y * smp_y;
      s1_xy_r   <= smp_x * smp_y;
    end
  end

  // Stage 2: accumulate; clear after a set is handed off.
  always_ff @(posedge clk) begin
    if (!rst_n || push) begin
      cnt_r <= '0;
      sx_r  <= '0;
      sy_r  <= '0;
      sxx_r <= '0;
      syy_r <= '0;
      sxy_r <= '0;
      ovf_r <= 1'b0;
    end else if (s1_adv) begin
      cnt_r <= cnt_nxt;
      sx_r  <= sx_nxt;
      sy_r  <= sy_nxt;
      sxx_r <= sxx_nxt;
      syy_r <= syy_nxt;
      sxy_r <= sxy_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= LIMIT)
    else $error("pair count beyond limit");

endmodule

// ----- src/spc_fifo.sv -----
// Short queue of accumulated sum sets between front and back.
`timescale 1ns / 1ps
module spc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = spc_pkg::FIFO_DEPTH_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wp_r, rp_r;
  logic [CW-1:0]    cnt_r;

  assign full     = (cnt_r == CW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);
      end
      if (pop) begin
        rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + AW'(1);
      end
      cnt_r <= cnt_r + CW'(push) - CW'(pop);
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
    else $error("push into full queue");
  a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n) empty |-> !pop)
    else $error("pop from empty queue");

endmodule

// ----- src/spc_mul.sv -----
// Sequential signed shift-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps
module spc_mul #(
  parameter int WIDTH = 73,
  localparam int CW = $clog2(WIDTH + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic signed [WIDTH-1:0]   op_a,
  input  logic signed [WIDTH-1:0]   op_b,
  output logic                      done,
  output logic signed [2*WIDTH-1:0] prod
);

  logic [2*WIDTH-1:0] acc_r, mc_r;
  logic [WIDTH-1:0]   mp_r;
  logic [CW-1:0]      cnt_r;
  logic               busy_r, neg_r, done_r;
  logic [WIDTH-1:0]   ua, ub;

  assign ua   = op_a[WIDTH-1] ? -op_a : op_a;
  assign ub   = op_b[WIDTH-1] ? -op_b : op_b;
  assign done = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      acc_r <= '0;
      mc_r  <= {{WIDTH{1'b0}}, ua};
      mp_r  <= ub;
      neg_r <= op_a[WIDTH-1] ^ op_b[WIDTH-1];
      cnt_r <= CW'(WIDTH);
    end else if (busy_r) begin
      if (cnt_r != '0) begin
        if (mp_r[0]) begin
          acc_r <= acc_r + mc_r;
        end
        mc_r  <= mc_r << 1;
        mp_r  <= mp_r >> 1;
        cnt_r <= cnt_r - CW'(1);
      end else begin
        prod <= neg_r ? -acc_r : acc_r;
      end
    end
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("multiplier done without a job");

endmodule

// ----- src/spc_back.sv -----
// Back end: variances, covariance and bitwise ratio search for one sum set.
`timescale 1ns / 1ps
module spc_back #(
  parameter int SAMPLE_WIDTH = spc_pkg::SAMPLE_WIDTH_DEF,
  parameter int COUNT_LOG2   = spc_pkg::COUNT_LOG2_DEF,
  localparam int NW    = COUNT_LOG2 + 1,
  localparam int SXW   = SAMPLE_WIDTH + COUNT_LOG2 + 1,
  localparam int SQW   = 2 * SAMPLE_WIDTH + COUNT_LOG2 - 1,
  localparam int SPW   = 2 * SAMPLE_WIDTH + COUNT_LOG2,
  localparam int SNAPW = NW + 2 * SXW + 2 * SQW + SPW + 1,
  localparam int VW    = 2 * SAMPLE_WIDTH + 2 * COUNT_LOG2 + 1
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  fifo_empty,
  input  logic [SNAPW-1:0]                      snap,
  output logic                                  pop,
  output logic                                  mul_start,
  output logic signed [VW-1:0]                  mul_a,
  output logic signed [VW-1:0]                  mul_b,
  input  logic                                  mul_done,
  input  logic signed [2*VW-1:0]                mul_prod,
  output logic                                  res_valid,
  input  logic                                  res_ready,
  output logic signed [spc_pkg::Q_BITS-1:0]     res_corr,
  output logic [spc_pkg::STATUS_W-1:0]          res_status
);

  localparam int RW  = 2 * VW + 2 * spc_pkg::Q_BITS;
  localparam int QBW = $clog2(spc_pkg::Q_BITS);

  localparam int O_SX  = NW;
  localparam int O_SY  = O_SX + SXW;
  localparam int O_SXX = O_SY + SXW;
  localparam int O_SYY = O_SXX + SQW;
  localparam int O_SXY = O_SYY + SQW;
  localparam int O_OVF = O_SXY + SPW;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ISSUE = 3'd1;
  localparam logic [2:0] ST_WAIT  = 3'd2;
  localparam logic [2:0] ST_CHECK = 3'd3;
  localparam logic [2:0] ST_SQA   = 3'd4;
  localparam logic [2:0] ST_SQB   = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0]            st_r;
  logic [2:0]            mi_r;
  logic [NW-1:0]         n_r;
  logic signed [SXW-1:0] sx_r, sy_r;
  logic [SQW-1:0]        sxx_r, syy_r;
  logic signed [SPW-1:0] sxy_r;
  logic                  ovf_r, deg_r;
  logic signed [VW-1:0]  pa_r, vx_r, vy_r, cov_r;
  logic [RW-1:0]         p_r, t_r, s_r, qs_r, p2_r, sp_r, qn_r;
  logic [spc_pkg::Q_BITS-1:0] q_r, q_cap;
  logic [QBW-1:0]        bit_r;
  logic                  out_valid_r;
  logic signed [spc_pkg::Q_BITS-1:0] corr_r;
  logic [spc_pkg::STATUS_W-1:0]      stat_r;

  logic signed [VW-1:0] n_e, sx_e, sy_e, sxx_e, syy_e, sxy_e, mag;
  logic signed [VW-1:0] prod_lo;
  logic [RW-1:0]        cand;
  logic                 out_free;

  assign n_e     = {{(VW-NW){1'b0}}, n_r};
  assign sx_e    = {{(VW-SXW){sx_r[SXW-1]}}, sx_r};
  assign sy_e    = {{(VW-SXW){sy_r[SXW-1]}}, sy_r};
  assign sxx_e   = {{(VW-SQW){1'b0}}, sxx_r};
  assign syy_e   = {{(VW-SQW){1'b0}}, syy_r};
  assign sxy_e   = {{(VW-SPW){sxy_r[SPW-1]}}, sxy_r};
  assign mag     = cov_r[VW-1] ? -cov_r : cov_r;
  assign prod_lo = mul_prod[VW-1:0];
  assign cand    = sp_r + qs_r;
  assign out_free = !out_valid_r || res_ready;
  assign q_cap   = (q_r > spc_pkg::CORR_MAX) ? spc_pkg::CORR_MAX : q_r;

  assign pop       = (st_r == ST_IDLE) && !fifo_empty;
  assign mul_start = (st_r == ST_ISSUE);

  always_comb begin
    unique case (mi_r)
      spc_pkg::MUL_N_SXX: begin mul_a = n_e;   mul_b = sxx_e; end
      spc_pkg::MUL_SX_SX: begin mul_a = sx_e;  mul_b = sx_e;  end
      spc_pkg::MUL_N_SYY: begin mul_a = n_e;   mul_b = syy_e; end
      spc_pkg::MUL_SY_SY: begin mul_a = sy_e;  mul_b = sy_e;  end
      spc_pkg::MUL_N_SXY: begin mul_a = n_e;   mul_b = sxy_e; end
      spc_pkg::MUL_SX_SY: begin mul_a = sx_e;  mul_b = sy_e;  end
      spc_pkg::MUL_VX_VY: begin mul_a = vx_r;  mul_b = vy_r;  end
      default:            begin mul_a = mag;   mul_b = mag;   end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      unique case (st_r)
        ST_IDLE: begin
          if (!fifo_empty) begin
            st_r <= ST_ISSUE;
          end
        end
        ST_ISSUE: st_r <= ST_WAIT;
        ST_WAIT: begin
          if (mul_done) begin
            if (mi_r == spc_pkg::MUL_SX_SY) begin
              st_r <= ST_CHECK;
            end else if (mi_r == spc_pkg::MUL_COV_SQ) begin
              st_r <= ST_SQA;
            end else begin
              st_r <= ST_ISSUE;
            end
          end
        end
        ST_CHECK: begin
          if (vx_r <= 0 || vy_r <= 0) begin
            st_r <= ST_DONE;
          end else begin
            st_r <= ST_ISSUE;
          end
        end
        ST_SQA: st_r <= ST_SQB;
        ST_SQB: begin
          if (bit_r == '0) begin
            st_r <= ST_DONE;
          end else begin
            st_r <= ST_SQA;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            st_r <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      ST_IDLE: begin
        if (!fifo_empty) begin
          n_r   <= snap[NW-1:0];
          sx_r  <= snap[O_SY-1:O_SX];
          sy_r  <= snap[O_SXX-1:O_SY];
          sxx_r <= snap[O_SYY-1:O_SXX];
          syy_r <= snap[O_SXY-1:O_SYY];
          sxy_r <= snap[O_OVF-1:O_SXY];
          ovf_r <= snap[O_OVF];
          mi_r  <= spc_pkg::MUL_N_SXX;
          deg_r <= 1'b0;
          q_r   <= '0;
        end
      end
      ST_WAIT: begin
        if (mul_done) begin
          unique case (mi_r)
            spc_pkg::MUL_N_SXX,
            spc_pkg::MUL_N_SYY,
            spc_pkg::MUL_N_SXY: pa_r  <= prod_lo;
            spc_pkg::MUL_SX_SX: vx_r  <= pa_r - prod_lo;
            spc_pkg::MUL_SY_SY: vy_r  <= pa_r - prod_lo;
            spc_pkg::MUL_SX_SY: cov_r <= pa_r - prod_lo;
            spc_pkg::MUL_VX_VY: p_r   <= RW'(mul_prod);
            default: begin
              t_r   <= RW'(mul_prod) << spc_pkg::FRAC_SHIFT;
              s_r   <= '0;
              qs_r  <= '0;
              p2_r  <= p_r << (2 * (spc_pkg::Q_BITS - 1));
              bit_r <= QBW'(spc_pkg::Q_BITS - 1);
            end
          endcase
          if (mi_r != spc_pkg::MUL_SX_SY && mi_r != spc_pkg::MUL_COV_SQ) begin
            mi_r <= mi_r + 3'd1;
          end
        end
      end
      ST_CHECK: begin
        deg_r <= (vx_r <= 0 || vy_r <= 0);
        mi_r  <= spc_pkg::MUL_VX_VY;
      end
      ST_SQA: begin
        // Trial square = q^2*p + 2^(b+1)*q*p + 2^(2b)*p, built from shifted terms.
        sp_r <= s_r + p2_r;
        qn_r <= qs_r + (p2_r << 1);
      end
      ST_SQB: begin
        if (cand <= t_r) begin
          s_r  <= cand;
          qs_r <= qn_r >> 1;
          q_r  <= q_r | (spc_pkg::Q_BITS'(1) << bit_r);
        end else begin
          qs_r <= qs_r >> 1;
        end
        p2_r  <= p2_r >> 2;
        bit_r <= bit_r - QBW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (st_r == ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (res_ready) begin
      out_valid_r <= 1'b0;
    end
    if (st_r == ST_DONE && out_free) begin
      if (deg_r) begin
        corr_r <= '0;
      end else begin
        corr_r <= cov_r[VW-1] ? -q_cap : q_cap;
      end
      priority if (ovf_r) begin
        stat_r <= spc_pkg::STAT_OVF;
      end else if (deg_r) begin
        stat_r <= spc_pkg::STAT_DEGEN;
      end else begin
        stat_r <= spc_pkg::STAT_OK;
      end
    end
  end

  assign res_valid  = out_valid_r;
  assign res_corr   = corr_r;
  assign res_status = stat_r;

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && stat_r == spc_pkg::STAT_DEGEN) |-> (corr_r == '0))
    else $error("degenerate result with nonzero correlation");

endmodule

// ----- verif/tb_streaming_pearson_correlation_unit.sv -----
// Self-checking testbench for the streaming Pearson correlation unit.
`timescale 1ns / 1ps
module tb_streaming_pearson_correlation_unit;

  localparam int SW     = spc_pkg::SAMPLE_WIDTH_DEF;
  localparam int CL2    = spc_pkg::COUNT_LOG2_DEF;
  localparam int QB     = spc_pkg::Q_BITS;
  localparam int IN_W   = ((2 * SW + 7) / 8) * 8;
  // Per-set time budget for the back end, with margin.
  localparam int SET_CYCLES = 8 * (2 * SW + 2 * CL2 + 1 + 3) + 2 * QB + 4;
  localparam int SETTLE_CYCLES = 2 * SET_CYCLES + 20;

  typedef logic signed [319:0] wide_t;

  typedef struct packed {
    logic signed [spc_pkg::Q_BITS-1:0] corr;
    logic [spc_pkg::STATUS_W-1:0]      stat;
  } corr_result_t;

  logic                         clk;
  logic                         rst_n;
  logic                         in_tvalid;
  logic                         in_tready;
  logic [IN_W-1:0]              in_tdata;   // sample_x, sample_y, zero fill
  logic                         in_tlast;
  logic                         out_tvalid;
  logic                         out_tready;
  logic [spc_pkg::Q_BITS-1:0]   out_tdata;  // correlation
  logic [spc_pkg::STATUS_W-1:0] out_tuser;  // status

  streaming_pearson_correlation_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  // Predictor state: pair count and exact running sums.
  logic signed [63:0]  pair_cnt;
  logic signed [127:0] acc_x, acc_y, acc_xx, acc_yy, acc_xy;
  bit                  count_ovf;

  corr_result_t corr_expected[$];
  int           error_count;
  int           gap_pct;
  int           stall_pct;
  bit           hold_off;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stop a hung run.
  initial begin
    #30ms;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic void clear_sums();
    pair_cnt  = '0;
    acc_x     = '0;
    acc_y     = '0;
    acc_xx    = '0;
    acc_yy    = '0;
    acc_xy    = '0;
    count_ovf = 1'b0;
  endfunction

  // Accumulate one pair; on the last pair push the expected coefficient.
  function automatic void predict_pair(logic signed [SW-1:0] x, logic signed [SW-1:0] y,
                                       bit last);
    wide_t        wn, vx, vy, cov, mag, prod, target, wc;
    logic [31:0]  q, c;
    bit           degen;
    corr_result_t res;
    if (pair_cnt < (64'sd1 <<< CL2)) begin
      pair_cnt = pair_cnt + 1;
      acc_x  = acc_x + x;
      acc_y  = acc_y + y;
      acc_xx = acc_xx + x * x;
      acc_yy = acc_yy + y * y;
      acc_xy = acc_xy + x * y;
    end else begin
      count_ovf = 1'b1;
    end
    if (!last) return;
    wn  = wide_t'(pair_cnt);
    vx  = wn * wide_t'(acc_xx) - wide_t'(acc_x) * wide_t'(acc_x);
    vy  = wn * wide_t'(acc_yy) - wide_t'(acc_y) * wide_t'(acc_y);
    cov = wn * wide_t'(acc_xy) - wide_t'(acc_x) * wide_t'(acc_y);
    degen = (vx <= 0) || (vy <= 0);
    res.corr = '0;
    if (!degen) begin
      // Integer search for q with q*q*vx*vy <= 2^30*cov*cov.
      mag    = (cov < 0) ? -cov : cov;
      prod   = vx * vy;
      target = (mag * mag) <<< spc_pkg::FRAC_SHIFT;
      q = '0;
      for (int b = QB - 1; b >= 0; b--) begin
        c  = q | (32'd1 << b);
        wc = wide_t'(c);
        if (wc * wc * prod <= target) q = c;
      end
      if (q > 32'(spc_pkg::CORR_MAX)) q = 32'(spc_pkg::CORR_MAX);
      res.corr = (cov < 0) ? -q[QB-1:0] : q[QB-1:0];
    end
    if (count_ovf)  res.stat = spc_pkg::STAT_OVF;
    else if (degen) res.stat = spc_pkg::STAT_DEGEN;
    else            res.stat = spc_pkg::STAT_OK;
    corr_expected.push_back(res);
    clear_sums();
  endfunction

  // Receiver: stall at random, or hold off entirely during the pressure test.
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= !hold_off && ($urandom_range(99) >= stall_pct);
  end

  // Compare each accepted result word with the oldest expectation.
  always @(posedge clk) begin
    corr_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (corr_expected.size() == 0) begin
        $error("unexpected result word: correlation %0d status %0d",
               $signed(out_tdata), out_tuser);
        error_count++;
      end else begin
        want = corr_expected.pop_front();
        if (out_tdata !== want.corr) begin
          $error("correlation: expected %0d, actual %0d", want.corr, $signed(out_tdata));
          error_count++;
        end
        if (out_tuser !== want.stat) begin
          $error("status: expected %0d, actual %0d", want.stat, out_tuser);
          error_count++;
        end
      end
    end
  end

  // Offer one word, with a random gap first; hold until accepted.
  task automatic send_pair(logic signed [SW-1:0] x, logic signed [SW-1:0] y, bit last);
    while ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_W'({y, x});
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_pair(x, y, last);
  endtask

  // Drop valid and wait for every expected result to drain.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (corr_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_set(int len, int span);
    logic signed [SW-1:0] x, y;
    for (int i = 0; i < len; i++) begin
      if (span == 0) begin
        x = SW'($urandom);
        y = SW'($urandom);
      end else begin
        x = SW'($signed($urandom_range(2 * span)) - span);
        y = SW'($signed($urandom_range(2 * span)) - span);
      end
      send_pair(x, y, i == len - 1);
    end
  endtask

  task automatic test_directed();
    gap_pct = 0; stall_pct = 0;
    // Single pair: zero variance.
    send_pair(16'sh7FFF, -16'sh8000, 1'b1);
    // Extremes with perfect correlation; magnitude clamps to full scale.
    send_pair(-16'sh8000, -16'sh8000, 1'b0);
    send_pair(16'sh7FFF, 16'sh7FFF, 1'b1);
    // Perfect anti-correlation at the extremes.
    send_pair(-16'sh8000, 16'sh7FFF, 1'b0);
    send_pair(16'sh7FFF, -16'sh8000, 1'b1);
    // Constant x: zero variance on one side only.
    send_pair(16'sd5, 16'sd1, 1'b0);
    send_pair(16'sd5, -16'sd9, 1'b0);
    send_pair(16'sd5, 16'sd300, 1'b1);
    // Constant y.
    send_pair(16'sd1, 16'sd0, 1'b0);
    send_pair(-16'sd2, 16'sd0, 1'b1);
    // Partial correlation with small and mixed values.
    send_pair(16'sd1, 16'sd2, 1'b0);
    send_pair(16'sd2, 16'sd1, 1'b0);
    send_pair(16'sd3, 16'sd4, 1'b0);
    send_pair(-16'sd1, -16'sd1, 1'b1);
    send_pair(16'sh0001, 16'sh5555, 1'b0);
    send_pair(-16'sh5556, 16'sh2AAA, 1'b0);
    send_pair(16'sh7FFE, -16'sh0001, 1'b1);
    drain();
  endtask

  task automatic test_random(int items, int gp, int sp);
    int sent, len;
    gap_pct = gp; stall_pct = sp;
    sent = 0;
    while (sent < items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 20) : $urandom_range(6, 1);
      send_set(len, ($urandom_range(3) == 0) ? $urandom_range(8) : 0);
      sent += len;
    end
    drain();
  endtask

  // Hold the receiver off while sets keep coming, so the queue fills.
  task automatic test_backpressure();
    gap_pct = 0; stall_pct = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (6 * SET_CYCLES) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 20; i++) send_set(3, 0);
    join
    drain();
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;
    hold_off  = 1'b0;
    gap_pct   = 0;
    stall_pct = 0;
    error_count = 0;
    clear_sums();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(215, 0, 0);
    test_random(215, 55, 0);
    test_random(215, 0, 55);
    test_random(215, 30, 30);
    test_backpressure();

    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
